// File: hw/rtl/mbsp_pkg.sv
// Shared types, byte codes and length tables for the MIDI byte stream parser.
`timescale 1ns / 1ps

package mbsp_pkg;

   localparam logic [7:0] STATUS_MIN   = 8'h80;
   localparam logic [7:0] EXCL_OPEN    = 8'hF0;
   localparam logic [7:0] EXCL_CLOSE   = 8'hF7;
   localparam logic [7:0] REALTIME_MIN = 8'hF8;
   localparam logic [7:0] ACTIVE_SENSE = 8'hFE;

   localparam logic [1:0] KIND_RT    = 2'd0;
   localparam logic [1:0] KIND_MSG   = 2'd1;
   localparam logic [1:0] KIND_SYSEX = 2'd2;
   localparam logic [1:0] KIND_CHUNK = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STORE,
      ST_PREP,
      ST_DRAIN,
      ST_RT
   } state_type;

   typedef struct packed {
      logic take;
      logic store;
      logic prep;
      logic drain_load;
      logic rt_load;
   } cmd_type;

   typedef struct packed {
      logic rt_emit;
      logic excl_close;
      logic data_ok;
      logic store_emit;
      logic out_free;
      logic drain_last;
   } status_type;

   // message length of a voice status, indexed by status bits 6:4
   function automatic logic [1:0] chan_msg_length(input logic [2:0] idx);
      logic [1:0] len;
      case (idx)
         3'd0, 3'd1, 3'd2, 3'd3: len = 2'd3;
         3'd4, 3'd5:             len = 2'd2;
         3'd6:                   len = 2'd3;
         default:                len = 2'd0;
      endcase
      return len;
   endfunction

   // message length of a system common status, indexed by status bits 2:0
   function automatic logic [1:0] sys_msg_length(input logic [2:0] idx);
      logic [1:0] len;
      case (idx)
         3'd1:       len = 2'd2;
         3'd2:       len = 2'd3;
         3'd3:       len = 2'd2;
         3'd6, 3'd7: len = 2'd1;
         default:    len = 2'd0;
      endcase
      return len;
   endfunction

endpackage

// File: hw/rtl/midi_byte_stream_parser.sv
// Top level of the MIDI byte stream parser: controller plus datapath.
//
// Raw MIDI bytes enter on req_ (one byte per word) and assembled messages leave
// on rsp_, one byte per word, with the message kind in rsp_tuser and rsp_tlast
// on the final byte. csr_wr_en/csr_wr_data write local_mode (1 drops real-time
// bytes and overflow chunks).
// Steps per input word:
//   status byte, dropped byte, stray end byte: accept only
//   real-time byte passed on: accept, then load the output word once the output register is free
//   data byte that completes nothing: accept, then store write
//   data byte that completes n bytes: accept, store write, read setup, then one
//   byte per cycle from the store's single read port while rsp_ is not stalled
//   sysex end that completes n bytes: the end byte is written on accept, then
//   read setup and one byte per cycle while rsp_ is not stalled.
// req_tready is low while a word is being worked on and during reset; the last
// output word may still wait in the output register while the next input word
// is accepted. A stall on rsp_ holds the output register and pauses draining.
// Synchronous reset clears running status, fill count, local_mode and the
// output valid; the message store needs no clearing pass.
`timescale 1ns / 1ps

module midi_byte_stream_parser
   import mbsp_pkg::*;
#(
   parameter int MSG_MAX = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] msg_kind
   output logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   mbsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   mbsp_datapath #(
      .MSG_MAX(MSG_MAX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hw/rtl/mbsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mbsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mbsp_ctrl.sv
// Controller state machine: sequences accept, store, drain and real-time output.
`timescale 1ns / 1ps

module mbsp_ctrl
   import mbsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (status.rt_emit) begin
                  state_in = ST_RT;
               end else if (status.excl_close) begin
                  state_in = ST_PREP;
               end else if (status.data_ok) begin
                  state_in = ST_STORE;
               end
            end
         end
         ST_STORE: begin
            state_in = status.store_emit ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (status.out_free && status.drain_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_RT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            // hold off input while reset is applied
            req_tready = !reset;
            cmd.take   = req_tvalid && !reset;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_DRAIN: begin
            cmd.drain_load = status.out_free;
         end
         ST_RT: begin
            cmd.rt_load = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// File: hw/rtl/mbsp_datapath.sv
// Datapath: running status, fill count, message store and output register.
`timescale 1ns / 1ps

module mbsp_datapath
   import mbsp_pkg::*;
#(
   parameter int MSG_MAX = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_tdata,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [1:0] rsp_tuser,
   output logic       rsp_tlast
);

   localparam int FW = $clog2(MSG_MAX + 1);
   localparam int AW = $clog2(MSG_MAX);

   logic          local_ff, local_in;
   logic [7:0]    rs_ff, rs_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [1:0]    exp_ff, exp_in;
   logic [7:0]    byte_ff, byte_in;
   logic [FW-1:0] count_ff, count_in;
   logic [1:0]    kind_ff, kind_in;
   logic [AW-1:0] k_ff, k_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic [1:0]    out_kind_ff, out_kind_in;
   logic          out_last_ff, out_last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [7:0]    rd_data;

   logic          is_rt, is_end, is_stat, is_data;
   logic          fill_full;
   logic [FW-1:0] fill_next;
   logic          store_done, store_over;

   assign is_rt   = req_tdata >= REALTIME_MIN;
   assign is_end  = req_tdata == EXCL_CLOSE;
   assign is_stat = (req_tdata >= STATUS_MIN) && !is_rt && !is_end;
   assign is_data = req_tdata < STATUS_MIN;

   assign fill_full  = fill_ff >= FW'(MSG_MAX);
   assign fill_next  = fill_full ? fill_ff : fill_ff + FW'(1);
   assign store_done = fill_next == FW'(exp_ff);
   assign store_over = fill_next >= FW'(MSG_MAX);

   assign status.rt_emit    = is_rt && !local_ff && (req_tdata != ACTIVE_SENSE);
   assign status.excl_close = is_end && (rs_ff == EXCL_OPEN);
   assign status.data_ok    = is_data && (rs_ff != 8'h00);
   assign status.store_emit = store_done || (store_over && !local_ff);
   assign status.out_free   = !out_valid_ff || rsp_tready;
   assign status.drain_last = (FW'(k_ff) + FW'(1)) == count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ff     <= 1'b0;
         rs_ff        <= 8'h00;
         fill_ff      <= '0;
         exp_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         local_ff     <= local_in;
         rs_ff        <= rs_in;
         fill_ff      <= fill_in;
         exp_ff       <= exp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      count_ff    <= count_in;
      kind_ff     <= kind_in;
      k_ff        <= k_in;
      out_byte_ff <= out_byte_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      local_in = csr_wr_en ? csr_wr_data : local_ff;
   end

   // message bookkeeping and store writes
   always_comb begin
      rs_in    = rs_ff;
      fill_in  = fill_ff;
      exp_in   = exp_ff;
      byte_in  = byte_ff;
      count_in = count_ff;
      kind_in  = kind_ff;
      wr_en    = 1'b0;
      wr_addr  = fill_ff[AW-1:0];
      wr_data  = req_tdata;
      if (cmd.take) begin
         byte_in = req_tdata;
         if (is_end) begin
            if (rs_ff == EXCL_OPEN) begin
               wr_en    = !fill_full;
               count_in = fill_next;
               kind_in  = KIND_SYSEX;
            end
            rs_in   = 8'h00;
            fill_in = '0;
         end else if (is_stat) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            exp_in  = (req_tdata >= EXCL_OPEN) ? sys_msg_length(req_tdata[2:0])
                                               : chan_msg_length(req_tdata[6:4]);
            rs_in   = req_tdata;
            fill_in = FW'(1);
         end else if (status.data_ok && (fill_ff == '0) && (rs_ff != EXCL_OPEN)) begin
            // put the running status back in front of the data
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = rs_ff;
            fill_in = FW'(1);
         end
      end else if (cmd.store) begin
         wr_en   = !fill_full;
         wr_data = byte_ff;
         if (store_done) begin
            count_in = fill_next;
            kind_in  = KIND_MSG;
            if (rs_ff >= EXCL_OPEN) begin
               rs_in = 8'h00;
            end
            fill_in = '0;
         end else if (store_over) begin
            count_in = fill_next;
            kind_in  = KIND_CHUNK;
            fill_in  = '0;
         end else begin
            fill_in = fill_next;
         end
      end
   end

   // drain pointer; the RAM reads at the next pointer so its registered data is ready in the next cycle
   always_comb begin
      k_in = k_ff;
      if (cmd.prep) begin
         k_in = '0;
      end else if (cmd.drain_load) begin
         k_in = k_ff + AW'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      if (cmd.drain_load) begin
         out_valid_in = 1'b1;
         out_byte_in  = rd_data;
         out_kind_in  = kind_ff;
         out_last_in  = status.drain_last;
      end else if (cmd.rt_load) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_ff;
         out_kind_in  = KIND_RT;
         out_last_in  = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   mbsp_ram #(
      .WIDTH(8),
      .DEPTH(MSG_MAX)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(k_in),
      .rd_data(rd_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MSG_MAX))
      else $error("fill count beyond store depth");

   a_drain_count: assert property (@(posedge clock) disable iff (reset)
      cmd.drain_load |-> (count_ff != '0) && (kind_ff != KIND_RT))
      else $error("drain with empty count or real-time kind");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.drain_load || cmd.rt_load) |-> (!out_valid_ff || rsp_tready))
      else $error("output register overwritten while held");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && is_end) |=> (rs_ff == 8'h00) && (fill_ff == '0))
      else $error("end byte did not clear status and fill");

endmodule

// File: tb/tb_midi_byte_stream_parser.sv
// Self-checking testbench for the MIDI byte stream parser with running status.
`timescale 1ns / 1ps

module tb_midi_byte_stream_parser;
   import mbsp_pkg::*;

   localparam int STORE_DEPTH = 16;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       is_last;
   } midi_word_type;

   typedef enum logic [1:0] {
      RX_FREE,
      RX_JITTER,
      RX_CHOKE
   } rx_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   // model of the parser state
   logic       local_mode = 1'b0;
   logic [7:0] run_status = 8'h00;
   int         fill_count = 0;
   logic [1:0] msg_len = 2'd0;
   logic [7:0] msg_store [STORE_DEPTH];

   logic [7:0] pending_bytes [$];
   midi_word_type expected_words [$];
   midi_word_type want;

   int          burst_left = 0;
   int          gap_left = 0;
   rx_mode_type rx_mode = RX_FREE;
   int          rx_left = 0;

   int         errors = 0;
   int         bytes_sent = 0;
   int         words_checked = 0;
   int         msgs_ended = 0;
   int         mode_writes = 0;

   midi_byte_stream_parser #(
      .MSG_MAX(STORE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("[%0t] timeout: %0d words still expected", $time, expected_words.size());
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [1:0] voice_msg_len(input logic [2:0] hi);
      case (hi)
         3'd4, 3'd5: return 2'd2;
         3'd7:       return 2'd0;
         default:    return 2'd3;
      endcase
   endfunction

   function automatic logic [1:0] common_msg_len(input logic [2:0] lo);
      case (lo)
         3'd1, 3'd3: return 2'd2;
         3'd2:       return 2'd3;
         3'd6, 3'd7: return 2'd1;
         default:    return 2'd0;
      endcase
   endfunction

   task automatic keep_byte(input logic [7:0] b);
      if (fill_count < STORE_DEPTH) begin
         msg_store[fill_count] = b;
         fill_count++;
      end
   endtask

   task automatic flush_store(input logic [1:0] kind);
      int n;
      n = (fill_count > STORE_DEPTH) ? STORE_DEPTH : fill_count;
      for (int k = 0; k < n; k++) begin
         expected_words.push_back('{data: msg_store[k], kind: kind, is_last: (k == n - 1)});
      end
   endtask

   // work out the words that one accepted byte produces
   task automatic parse_midi_byte(input logic [7:0] b);
      if (b >= REALTIME_MIN) begin
         if (!local_mode && b != ACTIVE_SENSE)
            expected_words.push_back('{data: b, kind: KIND_RT, is_last: 1'b1});
      end else if (b == EXCL_CLOSE) begin
         if (run_status == EXCL_OPEN) begin
            keep_byte(b);
            flush_store(KIND_SYSEX);
         end
         run_status = 8'h00;
         fill_count = 0;
      end else if (b >= STATUS_MIN) begin
         msg_store[0] = b;
         msg_len = (b >= EXCL_OPEN) ? common_msg_len(b[2:0]) : voice_msg_len(b[6:4]);
         run_status = b;
         fill_count = 1;
      end else if (run_status != 8'h00) begin
         // restore the status byte in front of running-status data
         if (fill_count == 0 && run_status != EXCL_OPEN)
            keep_byte(run_status);
         keep_byte(b);
         if (fill_count == int'(msg_len)) begin
            flush_store(KIND_MSG);
            if (run_status >= EXCL_OPEN)
               run_status = 8'h00;
            fill_count = 0;
         end else if (fill_count >= STORE_DEPTH) begin
            if (!local_mode)
               flush_store(KIND_CHUNK);
            fill_count = 0;
         end
      end
   endtask

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'h00;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_midi_byte(req_tdata);
            bytes_sent++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_bytes.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: switch between free flow, jitter and heavy back-pressure
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(20, 120);
      end else begin
         rx_left--;
      end
      case (rx_mode)
         RX_FREE:   rsp_tready <= 1'b1;
         RX_JITTER: rsp_tready <= ($urandom_range(0, 3) != 0);
         default:   rsp_tready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $display("[%0t] unexpected word: data %h kind %0d last %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata !== want.data) begin
               $display("[%0t] out_byte mismatch: expected %h, got %h",
                        $time, want.data, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== want.kind) begin
               $display("[%0t] msg_kind mismatch: expected %0d, got %0d",
                        $time, want.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== want.is_last) begin
               $display("[%0t] last_byte mismatch: expected %b, got %b",
                        $time, want.is_last, rsp_tlast);
               errors++;
            end
            words_checked++;
            if (rsp_tlast)
               msgs_ended++;
         end
      end
   end

   // data byte, sometimes preceded by a real-time byte
   task automatic push_data(input logic [7:0] b);
      if ($urandom_range(0, 9) == 0)
         pending_bytes.push_back(8'(REALTIME_MIN + $urandom_range(0, 7)));
      pending_bytes.push_back(b);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input logic v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      local_mode = v;
      mode_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // queue well-formed messages with random content, plus some noise
   task automatic run_random(input int target);
      int start;
      int pick;
      int n;
      logic [7:0] st;
      start = pending_bytes.size() + bytes_sent;
      while (pending_bytes.size() + bytes_sent - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            st = 8'(8'h80 + $urandom_range(0, 111));
            pending_bytes.push_back(st);
            repeat ($urandom_range(1, 3)) begin
               for (int k = 1; k < int'(voice_msg_len(st[6:4])); k++)
                  push_data(8'($urandom_range(0, 127)));
            end
         end else if (pick < 55) begin
            st = 8'(EXCL_OPEN + $urandom_range(1, 3));
            pending_bytes.push_back(st);
            for (int k = 1; k < int'(common_msg_len(st[2:0])); k++)
               push_data(8'($urandom_range(0, 127)));
         end else if (pick < 65) begin
            // short common messages only leave by overflow
            pending_bytes.push_back(8'(EXCL_OPEN + $urandom_range(4, 6)));
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
            repeat (n) push_data(8'($urandom_range(0, 127)));
         end else if (pick < 85) begin
            pending_bytes.push_back(EXCL_OPEN);
            if ($urandom_range(0, 3) == 0)
               n = ($urandom_range(0, 2) == 0) ? 15 : $urandom_range(12, 36);
            else
               n = $urandom_range(0, 8);
            repeat (n) push_data(8'($urandom_range(0, 127)));
            if ($urandom_range(0, 5) != 0)
               pending_bytes.push_back(EXCL_CLOSE);
         end else if (pick < 93) begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            // stray end byte, then data with no status
            pending_bytes.push_back(EXCL_CLOSE);
            repeat ($urandom_range(1, 3)) push_data(8'($urandom_range(0, 127)));
         end
      end
   endtask

   logic [7:0] opening [25] = '{
      8'h00, 8'h7f, 8'hf7,
      8'h90, 8'h3c, 8'h7f, 8'h40, 8'h00,
      8'hc5, 8'h12,
      8'hf8, 8'hfe, 8'hff,
      8'hf1, 8'h05, 8'hf2, 8'h01, 8'h02, 8'hf3, 8'h07,
      8'hf0, 8'h01, 8'h7f, 8'hf7,
      8'he0
   };

   initial begin
      @(negedge reset);
      write_mode(1'b0);
      @(negedge clock);
      foreach (opening[i])
         pending_bytes.push_back(opening[i]);

      run_random(30);
      // hold the sender until every expected word is out
      wait_drained();
      run_random(30);
      wait_drained();

      write_mode(1'b1);
      run_random(45);
      wait_drained();

      write_mode(1'b0);
      run_random(45);
      wait_drained();

      if (expected_words.size() != 0) begin
         $display("[%0t] %0d expected words never arrived", $time, expected_words.size());
         errors++;
      end
      $display("Sent %0d bytes over %0d local-mode settings;", bytes_sent, mode_writes);
      $display("checked %0d output words in %0d messages", words_checked, msgs_ended);
      $display("Covered running status, real-time, sysex chunks and short common overflow");
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
